### design/rsd_pkg.sv
// ============================================================================
// rsd_pkg: shared types and constants of the RV32I subset decoder
// Holds the opcode values, the format and operation codes, the control-word
// layout with its per-format values, and the decoded result record.
// ============================================================================
package rsd_pkg;

    localparam int INSTR_W = 32;
    localparam int IMM_W   = 21;
    localparam int CTRL_W  = 11;

    // Major opcodes (instruction bits 6:0).
    localparam logic [6:0] OPC_R      = 7'h33;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    // funct7 value that marks an arithmetic right shift immediate.
    localparam logic [6:0] F7_ALT     = 7'h20;
    localparam logic [6:0] F7_ZERO    = 7'h00;

    // funct3 values that the decoder tests by name.
    localparam logic [2:0] F3_ADD     = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SLT     = 3'd2;
    localparam logic [2:0] F3_SLTU    = 3'd3;
    localparam logic [2:0] F3_XOR     = 3'd4;
    localparam logic [2:0] F3_SR      = 3'd5;
    localparam logic [2:0] F3_OR      = 3'd6;
    localparam logic [2:0] F3_AND     = 3'd7;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_SB   = 3'd4,
        FMT_UJ   = 3'd5
    } format_t;

    typedef enum logic [4:0] {
        OP_UNKNOWN, OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL,
        OP_SRA, OP_OR, OP_AND, OP_LB, OP_LH, OP_LW, OP_ADDI, OP_SLLI,
        OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_SRAI, OP_ORI, OP_ANDI,
        OP_JALR, OP_SB, OP_SH, OP_SW, OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_JAL
    } op_t;

    // Control word fields, most significant first.
    typedef struct packed {
        logic       reg_write;
        logic [1:0] wb_sel;
        logic       mem_read;
        logic       alu_a_src;
        logic       alu_b_src;
        logic [1:0] branch;
        logic       mem_write;
        logic [1:0] alu_op;
    } ctrl_t;

    localparam logic [1:0] WB_MEM     = 2'd0;
    localparam logic [1:0] WB_ALU     = 2'd1;
    localparam logic [1:0] WB_PC4     = 2'd2;
    localparam logic [1:0] BR_NONE    = 2'd0;
    localparam logic [1:0] BR_COND    = 2'd1;
    localparam logic [1:0] BR_JUMP    = 2'd2;
    localparam logic [1:0] ALUOP_ADD  = 2'b00;
    localparam logic [1:0] ALUOP_BR   = 2'b01;
    localparam logic [1:0] ALUOP_FUNC = 2'b10;

    localparam ctrl_t CTRL_R      = '{1'b1, WB_ALU, 1'b0, 1'b0, 1'b0, BR_NONE, 1'b0, ALUOP_FUNC};
    localparam ctrl_t CTRL_LOAD   = '{1'b1, WB_MEM, 1'b1, 1'b0, 1'b1, BR_NONE, 1'b0, ALUOP_ADD};
    localparam ctrl_t CTRL_OP_IMM = '{1'b1, WB_ALU, 1'b0, 1'b0, 1'b1, BR_NONE, 1'b0, ALUOP_FUNC};
    localparam ctrl_t CTRL_JALR   = '{1'b1, WB_PC4, 1'b0, 1'b0, 1'b1, BR_JUMP, 1'b0, ALUOP_ADD};
    localparam ctrl_t CTRL_STORE  = '{1'b0, WB_MEM, 1'b0, 1'b0, 1'b1, BR_NONE, 1'b1, ALUOP_ADD};
    localparam ctrl_t CTRL_BRANCH = '{1'b0, WB_MEM, 1'b0, 1'b0, 1'b0, BR_COND, 1'b0, ALUOP_BR};
    localparam ctrl_t CTRL_JAL    = '{1'b1, WB_PC4, 1'b0, 1'b1, 1'b1, BR_JUMP, 1'b0, ALUOP_ADD};

    // One decoded instruction, packed lowest field last so that the record
    // maps straight onto the output tdata layout.
    typedef struct packed {
        ctrl_t              control;
        logic [IMM_W-1:0]   imm;
        logic [6:0]         f7;
        logic [2:0]         f3;
        logic [4:0]         rs2;
        logic [4:0]         rs1;
        logic [4:0]         rd;
        op_t                op;
        format_t            fmt;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### design/rv32i_subset_decoder.sv
// ============================================================================
// rv32i_subset_decoder: RV32I subset instruction decoder
// Decodes one 32-bit instruction word per transaction into its format,
// operation, operand fields, immediate and control word.
// ============================================================================
// Path: input register, then result register, to the master side.
// Throughput: one instruction per cycle, set by the single decode pass
// between the two registers, while the master side is ready; under
// back-pressure the input register still takes a word while it is empty.
// Reset clears both valid flags and the held control word to zero.
module rv32i_subset_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    // Slave side.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata [31:0]: instruction_word.
    input  logic [rsd_pkg::INSTR_W-1:0]     s_axis_tdata,
    // Master side.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, lowest bit up: format_kind [2:0], operation_code [7:3],
    // dest_reg [12:8], source_reg_one [17:13], source_reg_two [22:18],
    // func_three [25:23], func_seven [32:26], immediate_value [53:33]
    // (two's complement), control_word [64:54], zero fill [71:65].
    output logic [rsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rsd_pkg::*;

    logic               in_valid;
    logic [INSTR_W-1:0] in_word;
    logic               advance;
    logic               out_free;
    result_t            decoded;

    logic               m_valid_reg;
    logic               m_valid_next;
    result_t            m_result_reg;

    // The control word lives in a register of its own so that an
    // unrecognized opcode can report the last valid control word.
    ctrl_t              held_control_reg;
    ctrl_t              held_control_next;

    // The result register can take a new transaction when it is empty or its
    // present one is being taken downstream this cycle.
    assign out_free = !m_valid_reg || m_axis_tready;
    assign advance  = in_valid && out_free;

    rsd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .advance  (advance),
        .valid    (in_valid),
        .word     (in_word)
    );

    rsd_decode u_decode (
        .word         (in_word),
        .held_control (held_control_reg),
        .result       (decoded)
    );

    always_comb
    begin
        m_valid_next      = m_valid_reg;
        held_control_next = held_control_reg;
        if (advance)
        begin
            m_valid_next      = 1'b1;
            // Unrecognized opcodes already carry the held value through.
            held_control_next = decoded.control;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg      <= 1'b0;
            held_control_reg <= '0;
        end
        else
        begin
            m_valid_reg      <= m_valid_next;
            held_control_reg <= held_control_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_result_reg <= decoded;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, m_result_reg};

    // A decoded transaction always lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_valid_reg)
        else $error("decoded transaction did not reach the result register");

    // The presented control word is always the held one.
    a_ctrl_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_result_reg.control == held_control_reg))
        else $error("result control word differs from held control word");

    // An unrecognized opcode reports nothing but the control word.
    a_none_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_result_reg.fmt == FMT_NONE)) |->
        ((m_result_reg.op == OP_UNKNOWN) && (m_result_reg.imm == '0) &&
         (m_result_reg.rd == '0) && (m_result_reg.rs1 == '0)))
        else $error("unrecognized opcode produced nonzero fields");

    // Store and branch formats have no destination register.
    a_no_rd_for_s_sb: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && ((m_result_reg.fmt == FMT_S) ||
                         (m_result_reg.fmt == FMT_SB))) |->
        (m_result_reg.rd == '0))
        else $error("store or branch reported a destination register");

    // The held control word only changes when a transaction is decoded.
    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(held_control_reg))
        else $error("held control word changed without a decode");

endmodule

### design/rsd_in_stage.sv
// ============================================================================
// rsd_in_stage: input register of the decoder
// Captures one instruction word per transaction and holds it until the
// decode stage passes it on to the result register.
// ============================================================================
module rsd_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rsd_pkg::INSTR_W-1:0] s_tdata,
    input  logic                        advance,
    output logic                        valid,
    output logic [rsd_pkg::INSTR_W-1:0] word
);
    import rsd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [INSTR_W-1:0] word_reg;
    logic               take;

    // The slot is free when empty or when its word leaves this cycle.
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= s_tdata;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

### design/rsd_decode.sv
// ============================================================================
// rsd_decode: combinational instruction field decoder
// Slices one instruction word into format, operation, register numbers,
// funct fields, immediate and control word.
// ============================================================================
module rsd_decode (
    input  logic [rsd_pkg::INSTR_W-1:0] word,
    input  rsd_pkg::ctrl_t              held_control,
    output rsd_pkg::result_t            result
);
    import rsd_pkg::*;

    logic [6:0]       opc;
    logic [4:0]       rd;
    logic [2:0]       f3;
    logic [4:0]       rs1;
    logic [4:0]       rs2;
    logic [6:0]       f7;
    logic [IMM_W-1:0] imm_i;
    logic [IMM_W-1:0] imm_s;
    logic [IMM_W-1:0] imm_sb;
    logic [IMM_W-1:0] imm_uj;
    logic [IMM_W-1:0] imm_shamt;

    assign opc = word[6:0];
    assign rd  = word[11:7];
    assign f3  = word[14:12];
    assign rs1 = word[19:15];
    assign rs2 = word[24:20];
    assign f7  = word[31:25];

    assign imm_i     = {{(IMM_W-12){word[31]}}, word[31:20]};
    assign imm_s     = {{(IMM_W-12){word[31]}}, word[31:25], word[11:7]};
    assign imm_sb    = {{(IMM_W-13){word[31]}}, word[31], word[7], word[30:25],
                        word[11:8], 1'b0};
    assign imm_uj    = {word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign imm_shamt = {{(IMM_W-5){1'b0}}, rs2};

    always_comb
    begin
        result         = '0;
        result.fmt     = FMT_NONE;
        result.op      = OP_UNKNOWN;
        result.control = held_control;
        case (opc)
            OPC_R:
            begin
                result.fmt     = FMT_R;
                result.rd      = rd;
                result.rs1     = rs1;
                result.rs2     = rs2;
                result.f3      = f3;
                result.f7      = f7;
                result.control = CTRL_R;
                case (f3)
                    F3_ADD:  result.op = (f7 != F7_ZERO) ? OP_SUB : OP_ADD;
                    F3_SLL:  result.op = OP_SLL;
                    F3_SLT:  result.op = OP_SLT;
                    F3_SLTU: result.op = OP_SLTU;
                    F3_XOR:  result.op = OP_XOR;
                    F3_SR:   result.op = (f7 != F7_ZERO) ? OP_SRA : OP_SRL;
                    F3_OR:   result.op = OP_OR;
                    default: result.op = OP_AND;
                endcase
            end
            OPC_LOAD:
            begin
                result.fmt     = FMT_I;
                result.rd      = rd;
                result.rs1     = rs1;
                result.f3      = f3;
                result.imm     = imm_i;
                result.control = CTRL_LOAD;
                case (f3)
                    3'd0:    result.op = OP_LB;
                    3'd1:    result.op = OP_LH;
                    3'd2:    result.op = OP_LW;
                    default: result.op = OP_UNKNOWN;
                endcase
            end
            OPC_OP_IMM:
            begin
                result.fmt     = FMT_I;
                result.rd      = rd;
                result.rs1     = rs1;
                result.f3      = f3;
                result.imm     = imm_i;
                result.control = CTRL_OP_IMM;
                case (f3)
                    F3_ADD:  result.op = OP_ADDI;
                    F3_SLL:  result.op = OP_SLLI;
                    F3_SLT:  result.op = OP_SLTI;
                    F3_SLTU: result.op = OP_SLTIU;
                    F3_XOR:  result.op = OP_XORI;
                    F3_SR:
                    begin
                        // Right shifts carry the shift amount, not the full
                        // immediate; funct7 picks logical or arithmetic.
                        result.imm = imm_shamt;
                        if (f7 == F7_ZERO)
                        begin
                            result.op = OP_SRLI;
                        end
                        else if (f7 == F7_ALT)
                        begin
                            result.op = OP_SRAI;
                            result.f7 = F7_ALT;
                        end
                        else
                        begin
                            result.op = OP_UNKNOWN;
                        end
                    end
                    F3_OR:   result.op = OP_ORI;
                    default: result.op = OP_ANDI;
                endcase
            end
            OPC_JALR:
            begin
                result.fmt     = FMT_I;
                result.rd      = rd;
                result.rs1     = rs1;
                result.f3      = f3;
                result.imm     = imm_i;
                result.op      = OP_JALR;
                result.control = CTRL_JALR;
            end
            OPC_STORE:
            begin
                result.fmt     = FMT_S;
                result.rs1     = rs1;
                result.rs2     = rs2;
                result.f3      = f3;
                result.imm     = imm_s;
                result.control = CTRL_STORE;
                case (f3)
                    3'd0:    result.op = OP_SB;
                    3'd1:    result.op = OP_SH;
                    3'd2:    result.op = OP_SW;
                    default: result.op = OP_UNKNOWN;
                endcase
            end
            OPC_BRANCH:
            begin
                result.fmt     = FMT_SB;
                result.rs1     = rs1;
                result.rs2     = rs2;
                result.f3      = f3;
                result.imm     = imm_sb;
                result.control = CTRL_BRANCH;
                case (f3)
                    3'd0:    result.op = OP_BEQ;
                    3'd1:    result.op = OP_BNE;
                    3'd4:    result.op = OP_BLT;
                    3'd5:    result.op = OP_BGE;
                    default: result.op = OP_UNKNOWN;
                endcase
            end
            OPC_JAL:
            begin
                result.fmt     = FMT_UJ;
                result.rd      = rd;
                result.imm     = imm_uj;
                result.op      = OP_JAL;
                result.control = CTRL_JAL;
            end
            default:
            begin
                result.fmt = FMT_NONE;
            end
        endcase
    end

endmodule

### dv/rv32i_subset_decoder_test.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32i_subset_decoder_test: self-checking bench for the RV32I subset decoder
// Feeds instruction words through the slave stream, predicts each decoded
// record with an independent decoder model that tracks the held control
// word, and checks the master stream field by field under random gaps and
// back-pressure.
// ============================================================================
module rv32i_subset_decoder_test;

    import rsd_pkg::*;

    localparam int RANDOM_WORDS = 1700;

    // Scoreboard: predicts the decoded record of every accepted instruction
    // and checks the records that leave the decoder, oldest first.
    class decode_scoreboard;
        ctrl_t   held_ctrl;
        result_t expected_decodes[$];
        int      errors;
        int      checked;
        int      format_seen[6];
        int      unknown_ops;

        function new();
            held_ctrl   = '0;
            errors      = 0;
            checked     = 0;
            unknown_ops = 0;
            foreach (format_seen[k])
                format_seen[k] = 0;
        endfunction

        function ctrl_t make_ctrl(logic rw, logic [1:0] wb, logic mr, logic as_a,
                                  logic bs, logic [1:0] br, logic mw,
                                  logic [1:0] aluop);
            ctrl_t c;
            c.reg_write = rw;
            c.wb_sel    = wb;
            c.mem_read  = mr;
            c.alu_a_src = as_a;
            c.alu_b_src = bs;
            c.branch    = br;
            c.mem_write = mw;
            c.alu_op    = aluop;
            return c;
        endfunction

        // Decodes one word and updates the held control word, which an
        // unrecognised opcode leaves untouched.
        function result_t decode_word(logic [31:0] w);
            result_t     r;
            logic [6:0]  opc;
            logic [6:0]  f7;
            logic [4:0]  rd;
            logic [4:0]  rs1;
            logic [4:0]  rs2;
            logic [2:0]  f3;
            logic [20:0] imm_i;
            opc   = w[6:0];
            rd    = w[11:7];
            f3    = w[14:12];
            rs1   = w[19:15];
            rs2   = w[24:20];
            f7    = w[31:25];
            imm_i = {{9{w[31]}}, w[31:20]};
            r     = '0;
            case (opc)
                OPC_R:
                begin
                    r.fmt = FMT_R;
                    r.rd  = rd;
                    r.rs1 = rs1;
                    r.rs2 = rs2;
                    r.f3  = f3;
                    r.f7  = f7;
                    // Any nonzero funct7 turns ADD into SUB and SRL into SRA.
                    case (f3)
                        F3_ADD:  r.op = (f7 != F7_ZERO) ? OP_SUB : OP_ADD;
                        F3_SLL:  r.op = OP_SLL;
                        F3_SLT:  r.op = OP_SLT;
                        F3_SLTU: r.op = OP_SLTU;
                        F3_XOR:  r.op = OP_XOR;
                        F3_SR:   r.op = (f7 != F7_ZERO) ? OP_SRA : OP_SRL;
                        F3_OR:   r.op = OP_OR;
                        default: r.op = OP_AND;
                    endcase
                    held_ctrl = make_ctrl(1'b1, WB_ALU, 1'b0, 1'b0, 1'b0, BR_NONE,
                                          1'b0, ALUOP_FUNC);
                end
                OPC_LOAD:
                begin
                    r.fmt = FMT_I;
                    r.rd  = rd;
                    r.rs1 = rs1;
                    r.f3  = f3;
                    r.imm = imm_i;
                    case (f3)
                        F3_ADD:  r.op = OP_LB;
                        F3_SLL:  r.op = OP_LH;
                        F3_SLT:  r.op = OP_LW;
                        default: r.op = OP_UNKNOWN;
                    endcase
                    held_ctrl = make_ctrl(1'b1, WB_MEM, 1'b1, 1'b0, 1'b1, BR_NONE,
                                          1'b0, ALUOP_ADD);
                end
                OPC_OP_IMM:
                begin
                    r.fmt = FMT_I;
                    r.rd  = rd;
                    r.rs1 = rs1;
                    r.f3  = f3;
                    r.imm = imm_i;
                    case (f3)
                        F3_ADD:  r.op = OP_ADDI;
                        F3_SLL:  r.op = OP_SLLI;
                        F3_SLT:  r.op = OP_SLTI;
                        F3_SLTU: r.op = OP_SLTIU;
                        F3_XOR:  r.op = OP_XORI;
                        F3_OR:   r.op = OP_ORI;
                        F3_AND:  r.op = OP_ANDI;
                        default:
                        begin
                            // Right shifts carry only the shift amount; funct7
                            // is reported just for the two legal encodings.
                            r.imm = {16'd0, rs2};
                            if (f7 == F7_ZERO)
                                r.op = OP_SRLI;
                            else if (f7 == F7_ALT)
                            begin
                                r.op = OP_SRAI;
                                r.f7 = F7_ALT;
                            end
                            else
                                r.op = OP_UNKNOWN;
                        end
                    endcase
                    held_ctrl = make_ctrl(1'b1, WB_ALU, 1'b0, 1'b0, 1'b1, BR_NONE,
                                          1'b0, ALUOP_FUNC);
                end
                OPC_JALR:
                begin
                    r.fmt = FMT_I;
                    r.rd  = rd;
                    r.rs1 = rs1;
                    r.f3  = f3;
                    r.imm = imm_i;
                    r.op  = OP_JALR;
                    held_ctrl = make_ctrl(1'b1, WB_PC4, 1'b0, 1'b0, 1'b1, BR_JUMP,
                                          1'b0, ALUOP_ADD);
                end
                OPC_STORE:
                begin
                    r.fmt = FMT_S;
                    r.rs1 = rs1;
                    r.rs2 = rs2;
                    r.f3  = f3;
                    r.imm = {{9{w[31]}}, w[31:25], w[11:7]};
                    case (f3)
                        F3_ADD:  r.op = OP_SB;
                        F3_SLL:  r.op = OP_SH;
                        F3_SLT:  r.op = OP_SW;
                        default: r.op = OP_UNKNOWN;
                    endcase
                    held_ctrl = make_ctrl(1'b0, WB_MEM, 1'b0, 1'b0, 1'b1, BR_NONE,
                                          1'b1, ALUOP_ADD);
                end
                OPC_BRANCH:
                begin
                    r.fmt = FMT_SB;
                    r.rs1 = rs1;
                    r.rs2 = rs2;
                    r.f3  = f3;
                    r.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    case (f3)
                        F3_ADD:  r.op = OP_BEQ;
                        F3_SLL:  r.op = OP_BNE;
                        F3_XOR:  r.op = OP_BLT;
                        F3_SR:   r.op = OP_BGE;
                        default: r.op = OP_UNKNOWN;
                    endcase
                    held_ctrl = make_ctrl(1'b0, WB_MEM, 1'b0, 1'b0, 1'b0, BR_COND,
                                          1'b0, ALUOP_BR);
                end
                OPC_JAL:
                begin
                    r.fmt = FMT_UJ;
                    r.rd  = rd;
                    r.op  = OP_JAL;
                    r.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                    held_ctrl = make_ctrl(1'b1, WB_PC4, 1'b0, 1'b1, 1'b1, BR_JUMP,
                                          1'b0, ALUOP_ADD);
                end
                default:
                begin
                end
            endcase
            r.control = held_ctrl;
            return r;
        endfunction

        function void note_instruction(logic [31:0] w);
            result_t r;
            r = decode_word(w);
            expected_decodes.push_back(r);
            format_seen[int'(r.fmt)]++;
            if (r.op == OP_UNKNOWN)
                unknown_ops++;
        endfunction

        function void report_error(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
                report_error($sformatf("record %0d %s: expected 0x%0h, got 0x%0h",
                                       checked, name, exp_v, act_v));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            result_t got;
            result_t exp_r;
            got = result_t'(data[RESULT_W-1:0]);
            if (expected_decodes.size() == 0)
            begin
                report_error($sformatf("unexpected record 0x%0h", data));
                return;
            end
            exp_r = expected_decodes.pop_front();
            compare_field("format_kind", exp_r.fmt, got.fmt);
            compare_field("operation_code", exp_r.op, got.op);
            compare_field("dest_reg", exp_r.rd, got.rd);
            compare_field("source_reg_one", exp_r.rs1, got.rs1);
            compare_field("source_reg_two", exp_r.rs2, got.rs2);
            compare_field("func_three", exp_r.f3, got.f3);
            compare_field("func_seven", exp_r.f7, got.f7);
            compare_field("immediate_value", exp_r.imm, got.imm);
            compare_field("control_word", exp_r.control, got.control);
            compare_field("zero fill", '0, data[OUT_TDATA_W-1:RESULT_W]);
            checked++;
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction

        function void flag_leftovers();
            while (expected_decodes.size() != 0)
            begin
                void'(expected_decodes.pop_front());
                report_error("expected record never arrived");
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [INSTR_W-1:0]     s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // When set, neither side inserts gaps, so the decoder runs at full rate.
    bit calm = 1'b0;

    decode_scoreboard sb = new();

    rv32i_subset_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [6:0] pick_opcode();
        case ($urandom_range(0, 6))
            0:       return OPC_R;
            1:       return OPC_LOAD;
            2:       return OPC_OP_IMM;
            3:       return OPC_JALR;
            4:       return OPC_STORE;
            5:       return OPC_BRANCH;
            default: return OPC_JAL;
        endcase
    endfunction

    // Mostly well-formed instructions with random operands; the rest is raw
    // noise, which nearly always carries an unrecognised opcode.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        logic [6:0]  opc;
        w = $urandom();
        if ($urandom_range(0, 99) < 12)
            return w;
        opc = pick_opcode();
        w[6:0] = opc;
        case (opc)
            OPC_R:
                if ($urandom_range(0, 3) != 0)
                    w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            OPC_OP_IMM:
                if (w[14:12] == F3_SR && $urandom_range(0, 4) != 0)
                    w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            OPC_LOAD, OPC_STORE:
                if ($urandom_range(0, 4) != 0)
                    w[14:12] = 3'($urandom_range(F3_ADD, F3_SLT));
            default:
            begin
            end
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pack_word(logic [6:0] f7, logic [4:0] rs2,
                                              logic [4:0] rs1, logic [2:0] f3,
                                              logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // Presents one instruction and holds it until the decoder takes it. tvalid
    // is only lowered when a gap precedes the word.
    task automatic send_word(input logic [31:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.note_instruction(w);
    endtask

    // Result side: checks each record taken and throttles tready.
    initial
    begin
        int stall_left;
        int n;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = n - 1;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [31:0] directed_words[$];
        int          drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register-register forms, every funct3, with register numbers spread
        // over their range; then SUB, SRA from an odd funct7, and AND with a
        // nonzero funct7 that must stay AND.
        for (int k = 0; k < 8; k++)
            directed_words.push_back(pack_word(F7_ZERO, 5'(k * 4 + 3), 5'(31 - k), 3'(k),
                                               5'(k * 4), OPC_R));
        directed_words.push_back(pack_word(F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_R));
        directed_words.push_back(pack_word(7'h7F, 5'd0, 5'd0, F3_SR, 5'd0, OPC_R));
        directed_words.push_back(pack_word(7'h01, 5'd7, 5'd9, F3_AND, 5'd11, OPC_R));
        // Loads: most negative and most positive offsets, one unlisted funct3.
        directed_words.push_back(pack_word(7'h40, 5'd0, 5'd31, F3_ADD, 5'd1, OPC_LOAD));
        directed_words.push_back(pack_word(7'h3F, 5'd31, 5'd0, F3_SLT, 5'd31, OPC_LOAD));
        directed_words.push_back(pack_word(7'h12, 5'd3, 5'd4, F3_OR, 5'd5, OPC_LOAD));
        // Immediate ALU forms, every funct3, plus SRAI, a right shift with an
        // illegal funct7, and SLLI whose upper immediate bits are set.
        for (int k = 0; k < 8; k++)
            directed_words.push_back(pack_word(F7_ZERO, 5'(31 - k), 5'(k), 3'(k),
                                               5'(k + 20), OPC_OP_IMM));
        directed_words.push_back(pack_word(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd2, OPC_OP_IMM));
        directed_words.push_back(pack_word(7'h7F, 5'd17, 5'd1, F3_SR, 5'd2, OPC_OP_IMM));
        directed_words.push_back(pack_word(7'h7F, 5'd31, 5'd8, F3_SLL, 5'd9, OPC_OP_IMM));
        // JALR decodes whatever funct3 holds.
        directed_words.push_back(pack_word(7'h7F, 5'd31, 5'd31, F3_AND, 5'd31, OPC_JALR));
        // Stores, including an unlisted funct3.
        directed_words.push_back(pack_word(7'h40, 5'd31, 5'd0, F3_ADD, 5'd0, OPC_STORE));
        directed_words.push_back(pack_word(7'h3F, 5'd0, 5'd31, F3_SLL, 5'd31, OPC_STORE));
        directed_words.push_back(pack_word(7'h55, 5'd10, 5'd20, F3_SLT, 5'd5, OPC_STORE));
        directed_words.push_back(pack_word(7'h7F, 5'd1, 5'd2, F3_SR, 5'd31, OPC_STORE));
        // Branches: every listed funct3 and one unlisted, offsets at both ends.
        directed_words.push_back(pack_word(7'h7F, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_BRANCH));
        directed_words.push_back(pack_word(7'h3F, 5'd0, 5'd0, F3_SLL, 5'd31, OPC_BRANCH));
        directed_words.push_back(pack_word(7'h40, 5'd5, 5'd6, F3_XOR, 5'd0, OPC_BRANCH));
        directed_words.push_back(pack_word(7'h00, 5'd7, 5'd8, F3_SR, 5'd1, OPC_BRANCH));
        directed_words.push_back(pack_word(7'h2A, 5'd9, 5'd3, F3_SLTU, 5'd30, OPC_BRANCH));
        // JAL with the most negative and most positive offsets.
        directed_words.push_back(32'h8000_0000 | 32'(OPC_JAL) | (32'd31 << 7));
        directed_words.push_back(32'h7FFF_F000 | 32'(OPC_JAL));
        // Unrecognised opcodes keep the last control word.
        directed_words.push_back(32'h0000_0000);
        directed_words.push_back(32'hFFFF_FFFF);
        directed_words.push_back(32'hFFFF_FF7F & 32'hFFFF_FFF7);

        foreach (directed_words[k])
            send_word(directed_words[k]);

        // Random part, with every fourth stretch run without any gaps.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = ((i / 150) % 4) == 3;
            send_word(random_word());
        end
        calm = 1'b0;
        // Drop tvalid at the edge that took the last word so that it is not
        // taken a second time.
        s_axis_tvalid <= 1'b0;

        drain = 0;
        while (sb.pending() != 0 && drain < 50000)
        begin
            @(posedge clk);
            drain++;
        end
        // The decoder holds at most two words in flight.
        repeat (8) @(posedge clk);
        sb.flag_leftovers();

        $display("Decoded %0d instructions: R %0d, I %0d, S %0d, SB %0d, UJ %0d,",
                 sb.checked, sb.format_seen[FMT_R], sb.format_seen[FMT_I],
                 sb.format_seen[FMT_S], sb.format_seen[FMT_SB], sb.format_seen[FMT_UJ]);
        $display("%0d unrecognised opcodes, %0d with unknown operation, %0d mismatches.",
                 sb.format_seen[FMT_NONE], sb.unknown_ops, sb.errors);
        if (sb.errors == 0)
            $display("rv32i_subset_decoder_test: done, clean");
        else
            $display("rv32i_subset_decoder_test: done, errors");
        $finish;
    end

    // Safety net well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d records still outstanding.", sb.pending());
        $display("rv32i_subset_decoder_test: done, errors");
        $finish;
    end

endmodule

### sim.f
design/rsd_pkg.sv
design/rsd_in_stage.sv
design/rsd_decode.sv
design/rv32i_subset_decoder.sv
dv/rv32i_subset_decoder_test.sv
